// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the bank mapper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Types, codes and constants shared by the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Default bank register widths
  localparam int ROM_BANK_BITS = 7;
  localparam int RAM_BANK_BITS = 2;

  // Port field widths
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int TARGET_W = 3;
  localparam int MAP_W    = 21;
  localparam int MTYPE_W  = 2;
  localparam int ROM_OUT_W = 7;
  localparam int RAM_OUT_W = 2;

  // Mapper codes
  localparam logic [MTYPE_W-1:0] MAPPER_NONE = 2'd0;
  localparam logic [MTYPE_W-1:0] MAPPER_MBC1 = 2'd1;
  localparam logic [MTYPE_W-1:0] MAPPER_MBC2 = 2'd2;

  // Target codes
  localparam logic [TARGET_W-1:0] TGT_BASE     = 3'd0;
  localparam logic [TARGET_W-1:0] TGT_ROM      = 3'd1;
  localparam logic [TARGET_W-1:0] TGT_EXT_RAM  = 3'd2;
  localparam logic [TARGET_W-1:0] TGT_BANK_REG = 3'd3;
  localparam logic [TARGET_W-1:0] TGT_RAM_DROP = 3'd4;

  // Bank register window select, address bits 14:13
  localparam logic [1:0] WIN_RAM_EN  = 2'd0;
  localparam logic [1:0] WIN_ROM_LO  = 2'd1;
  localparam logic [1:0] WIN_ROM_HI  = 2'd2;
  localparam logic [1:0] WIN_MODE    = 2'd3;

  // Data keys and masks
  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [3:0] RAM_DIS_KEY = 4'h0;
  localparam logic [7:0] ROM_LO_MASK = 8'd31;
  localparam logic [7:0] ROM_HI_MASK = 8'd224;

  // Restricted area, writes there are dropped
  localparam logic [ADDR_W-1:0] RESTRICT_LO = 16'hFEA0;
  localparam logic [ADDR_W-1:0] RESTRICT_HI = 16'hFEFF;

  // One bus access
  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } req_t;

  // Bank register write command
  typedef struct packed {
    logic              en;
    logic [1:0]        win;
    logic [DATA_W-1:0] data;
  } bank_wr_t;

  // Translation result
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [MAP_W-1:0]    mapped;
    logic                stores;
  } res_t;

endpackage

// ===== sv/cbm_translate.sv =====
// ----------------------------------------------------------------------------
// cbm_translate
// Decodes one bus access into target, cartridge address, store flag and bank register command.
// ----------------------------------------------------------------------------
module cbm_translate #(
  parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS,
  parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS
) (
  input  cbm_pkg::req_t            req,
  input  logic [ROM_BANK_BITS-1:0] rom_bank,
  input  logic [RAM_BANK_BITS-1:0] ram_bank,
  input  logic                     ram_enable,
  output cbm_pkg::res_t            res,
  output cbm_pkg::bank_wr_t        bank_wr
);

  logic [15:0] rom_ext;
  logic [15:0] ram_ext;
  logic        in_rom_sw;
  logic        in_ext_ram;
  logic        in_bank_reg;
  logic        in_restrict;
  logic [cbm_pkg::MAP_W-1:0] rom_addr;
  logic [cbm_pkg::MAP_W-1:0] ram_addr;

  // Region decode
  assign in_rom_sw   = (req.address[15:14] == 2'b01);
  assign in_ext_ram  = (req.address[15:13] == 3'b101);
  assign in_bank_reg = !req.address[15];
  assign in_restrict = (req.address >= cbm_pkg::RESTRICT_LO) &&
                       (req.address <  cbm_pkg::RESTRICT_HI);

  // Bank times window size is a concatenation; upper bits wrap off
  assign rom_ext  = 16'(rom_bank);
  assign ram_ext  = 16'(ram_bank);
  assign rom_addr = {rom_ext[6:0], req.address[13:0]};
  assign ram_addr = {ram_ext[7:0], req.address[12:0]};

  always_comb begin
    res.target = cbm_pkg::TGT_BASE;
    res.mapped = cbm_pkg::MAP_W'(req.address);
    res.stores = 1'b0;
    if (!req.is_write) begin
      if (in_rom_sw) begin
        res.target = cbm_pkg::TGT_ROM;
        res.mapped = rom_addr;
      end else if (in_ext_ram) begin
        res.target = cbm_pkg::TGT_EXT_RAM;
        res.mapped = ram_addr;
      end
    end else begin
      if (in_bank_reg) begin
        res.target = cbm_pkg::TGT_BANK_REG;
      end else if (in_ext_ram) begin
        res.mapped = ram_addr;
        res.target = ram_enable ? cbm_pkg::TGT_EXT_RAM : cbm_pkg::TGT_RAM_DROP;
        res.stores = ram_enable;
      end else begin
        res.stores = !in_restrict;
      end
    end
  end

  // Bank register command
  assign bank_wr.en   = req.is_write && in_bank_reg;
  assign bank_wr.win  = req.address[14:13];
  assign bank_wr.data = req.write_data;

endmodule

// ===== sv/cbm_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbm_bank_regs
// Bank state registers and their update for MBC1 and MBC2 writes.
// ----------------------------------------------------------------------------
module cbm_bank_regs #(
  parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS,
  parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cbm_pkg::MTYPE_W-1:0]   mapper_type,
  input  cbm_pkg::bank_wr_t             bank_wr,
  input  logic                          commit,
  output logic [ROM_BANK_BITS-1:0]      rom_bank,
  output logic [RAM_BANK_BITS-1:0]      ram_bank,
  output logic                          ram_enable,
  output logic [ROM_BANK_BITS-1:0]      rom_bank_nxt,
  output logic [RAM_BANK_BITS-1:0]      ram_bank_nxt,
  output logic                          ram_enable_nxt
);

  logic [ROM_BANK_BITS-1:0] rom_bank_r;
  logic [RAM_BANK_BITS-1:0] ram_bank_r;
  logic                     ram_enable_r;
  logic                     rom_mode_r;
  logic                     rom_mode_nxt;
  logic                     mbc1;
  logic                     mbc2;
  logic [7:0]               rom8;
  logic [7:0]               rom_lo8;
  logic [7:0]               rom_hi8;
  logic [7:0]               rom_m2_8;
  logic [7:0]               ram8;
  logic [ROM_BANK_BITS-1:0] rom_raw;
  logic                     rom_wr;

  assign mbc1 = (mapper_type == cbm_pkg::MAPPER_MBC1);
  assign mbc2 = (mapper_type == cbm_pkg::MAPPER_MBC2);

  // Candidate bank values, worked in bytes then cut to width
  assign rom8     = 8'(rom_bank_r);
  assign rom_lo8  = (rom8 & cbm_pkg::ROM_HI_MASK) | (bank_wr.data & cbm_pkg::ROM_LO_MASK);
  assign rom_hi8  = (rom8 & cbm_pkg::ROM_LO_MASK) | {1'b0, bank_wr.data[1:0], 5'b0};
  assign rom_m2_8 = {4'b0, bank_wr.data[3:0]};
  assign ram8     = {6'b0, bank_wr.data[1:0]};

  // Next state
  always_comb begin
    rom_raw        = rom_bank_r;
    rom_wr         = 1'b0;
    ram_bank_nxt   = ram_bank_r;
    ram_enable_nxt = ram_enable_r;
    rom_mode_nxt   = rom_mode_r;
    if (bank_wr.en && (mbc1 || mbc2)) begin
      case (bank_wr.win)
        cbm_pkg::WIN_RAM_EN: begin
          if (bank_wr.data[3:0] == cbm_pkg::RAM_EN_KEY) begin
            ram_enable_nxt = 1'b1;
          end else if (bank_wr.data[3:0] == cbm_pkg::RAM_DIS_KEY) begin
            ram_enable_nxt = 1'b0;
          end
        end
        cbm_pkg::WIN_ROM_LO: begin
          rom_wr  = 1'b1;
          rom_raw = mbc2 ? rom_m2_8[ROM_BANK_BITS-1:0] : rom_lo8[ROM_BANK_BITS-1:0];
        end
        cbm_pkg::WIN_ROM_HI: begin
          if (mbc1) begin
            if (rom_mode_r) begin
              rom_wr  = 1'b1;
              rom_raw = rom_hi8[ROM_BANK_BITS-1:0];
            end else begin
              ram_bank_nxt = ram8[RAM_BANK_BITS-1:0];
            end
          end
        end
        cbm_pkg::WIN_MODE: begin
          if (mbc1) begin
            rom_mode_nxt = !bank_wr.data[0];
            if (!bank_wr.data[0]) begin
              ram_bank_nxt = '0;
            end
          end
        end
        default: begin
          rom_raw = rom_bank_r;
        end
      endcase
    end
    // Bank zero reads as bank one
    if (rom_wr && (rom_raw == '0)) begin
      rom_bank_nxt = ROM_BANK_BITS'(1);
    end else begin
      rom_bank_nxt = rom_raw;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_r   <= ROM_BANK_BITS'(1);
      ram_bank_r   <= '0;
      ram_enable_r <= 1'b0;
      rom_mode_r   <= 1'b1;
    end else if (commit) begin
      rom_bank_r   <= rom_bank_nxt;
      ram_bank_r   <= ram_bank_nxt;
      ram_enable_r <= ram_enable_nxt;
      rom_mode_r   <= rom_mode_nxt;
    end
  end

  assign rom_bank   = rom_bank_r;
  assign ram_bank   = ram_bank_r;
  assign ram_enable = ram_enable_r;

endmodule

// ===== sv/cartridge_bank_mapper.sv =====
// Stages: input register, then result register, from input beat to result beat.
// Throughput: one beat per cycle unless out_ready stalls; the bank state updates as
//   each beat leaves the input register, so the next access sees it without a bubble.
// Reset (rst_n low, synchronous): both stages empty, mapper none, ROM bank 1,
//   RAM bank 0, RAM disabled, ROM banking mode.
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Translates CPU bus accesses through an MBC1/MBC2 style bank controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cartridge_bank_mapper #(
  parameter int ROM_BANK_BITS = cbm_pkg::ROM_BANK_BITS,
  parameter int RAM_BANK_BITS = cbm_pkg::RAM_BANK_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbm_pkg::MTYPE_W-1:0]     cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [cbm_pkg::ADDR_W-1:0]      in_address,
  input  logic [cbm_pkg::DATA_W-1:0]      in_write_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cbm_pkg::TARGET_W-1:0]    out_target,
  output logic [cbm_pkg::MAP_W-1:0]       out_mapped_address,
  output logic                            out_stores_data,
  output logic [cbm_pkg::ROM_OUT_W-1:0]   out_rom_bank_now,
  output logic [cbm_pkg::RAM_OUT_W-1:0]   out_ram_bank_now,
  output logic                            out_ram_enabled_now
);

  logic [cbm_pkg::MTYPE_W-1:0] mapper_type_r;
  logic                        s1_valid_r;
  cbm_pkg::req_t               s1_req_r;
  logic                        s1_adv;
  logic                        out_valid_r;
  cbm_pkg::res_t               out_res_r;
  logic [cbm_pkg::ROM_OUT_W-1:0] out_rom_r;
  logic [cbm_pkg::RAM_OUT_W-1:0] out_ram_r;
  logic                        out_ram_en_r;
  cbm_pkg::res_t               res;
  cbm_pkg::bank_wr_t           bank_wr;
  logic [ROM_BANK_BITS-1:0]    rom_bank;
  logic [RAM_BANK_BITS-1:0]    ram_bank;
  logic                        ram_enable;
  logic [ROM_BANK_BITS-1:0]    rom_bank_nxt;
  logic [RAM_BANK_BITS-1:0]    ram_bank_nxt;
  logic                        ram_enable_nxt;
  logic [15:0]                 rom_now_ext;
  logic [15:0]                 ram_now_ext;

  // Mapper type register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapper_type_r <= cbm_pkg::MAPPER_NONE;
    end else if (cfg_valid) begin
      mapper_type_r <= cfg_data;
    end
  end

  // Stage handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r.is_write   <= in_req_type;
      s1_req_r.address    <= in_address;
      s1_req_r.write_data <= in_write_data;
    end
  end

  cbm_translate #(
    .ROM_BANK_BITS (ROM_BANK_BITS),
    .RAM_BANK_BITS (RAM_BANK_BITS)
  ) u_translate (
    .req        (s1_req_r),
    .rom_bank   (rom_bank),
    .ram_bank   (ram_bank),
    .ram_enable (ram_enable),
    .res        (res),
    .bank_wr    (bank_wr)
  );

  cbm_bank_regs #(
    .ROM_BANK_BITS (ROM_BANK_BITS),
    .RAM_BANK_BITS (RAM_BANK_BITS)
  ) u_bank_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .mapper_type    (mapper_type_r),
    .bank_wr        (bank_wr),
    .commit         (s1_adv),
    .rom_bank       (rom_bank),
    .ram_bank       (ram_bank),
    .ram_enable     (ram_enable),
    .rom_bank_nxt   (rom_bank_nxt),
    .ram_bank_nxt   (ram_bank_nxt),
    .ram_enable_nxt (ram_enable_nxt)
  );

  // Reported banks are the state after the access
  assign rom_now_ext = 16'(rom_bank_nxt);
  assign ram_now_ext = 16'(ram_bank_nxt);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r    <= res;
      out_rom_r    <= rom_now_ext[cbm_pkg::ROM_OUT_W-1:0];
      out_ram_r    <= ram_now_ext[cbm_pkg::RAM_OUT_W-1:0];
      out_ram_en_r <= ram_enable_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target          = out_res_r.target;
  assign out_mapped_address  = out_res_r.mapped;
  assign out_stores_data     = out_res_r.stores;
  assign out_rom_bank_now    = out_rom_r;
  assign out_ram_bank_now    = out_ram_r;
  assign out_ram_enabled_now = out_ram_en_r;

  // Checks
  `ASSERT_SYNC(a_rom_bank_nonzero, clk, rst_n, rom_bank != '0, "ROM bank register reached zero")
  `ASSERT_SYNC(a_s1_holds, clk, rst_n, (s1_valid_r && out_valid_r && !out_ready) |=> s1_valid_r, "input stage lost a beat while result stalled")
  `ASSERT_SYNC(a_none_frozen, clk, rst_n, (s1_adv && (mapper_type_r == cbm_pkg::MAPPER_NONE)) |=> ($stable(rom_bank) && $stable(ram_bank) && $stable(ram_enable)), "bank state moved with no mapper")
  `ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> (!out_valid_r && !s1_valid_r && (rom_bank == ROM_BANK_BITS'(1))), "reset left the block busy or bank not one")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cartridge bank mapper. Bus accesses are queued,
// driven over the input channel with random gaps, translated by a local
// copy of the bank controller and compared field by field with each result
// beat. The mapper type is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD     = 20;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 80;
  localparam int TIMEOUT_CYCLES = 400000;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  localparam logic [cbm_pkg::MTYPE_W-1:0] MAPPER_UNUSED = 2'd3;

  // One expected translation, the fields of one result beat
  typedef struct packed {
    logic [cbm_pkg::TARGET_W-1:0]  target;
    logic [cbm_pkg::MAP_W-1:0]     mapped;
    logic                          stores;
    logic [cbm_pkg::ROM_OUT_W-1:0] rom_bank;
    logic [cbm_pkg::RAM_OUT_W-1:0] ram_bank;
    logic                          ram_en;
  } xlate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cbm_pkg::MTYPE_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           in_req_type = 1'b0;
  logic [cbm_pkg::ADDR_W-1:0]     in_address = '0;
  logic [cbm_pkg::DATA_W-1:0]     in_write_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [cbm_pkg::TARGET_W-1:0]   out_target;
  logic [cbm_pkg::MAP_W-1:0]      out_mapped_address;
  logic                           out_stores_data;
  logic [cbm_pkg::ROM_OUT_W-1:0]  out_rom_bank_now;
  logic [cbm_pkg::RAM_OUT_W-1:0]  out_ram_bank_now;
  logic                           out_ram_enabled_now;

  // Controller state as seen by the bench
  logic [cbm_pkg::MTYPE_W-1:0]    mapper_q   = cbm_pkg::MAPPER_NONE;
  logic [6:0]                     rom_bank_q = 7'd1;
  logic [1:0]                     ram_bank_q = 2'd0;
  logic                           ram_en_q   = 1'b0;
  logic                           rom_mode_q = 1'b1;

  cbm_pkg::req_t access_q[$];
  xlate_t        expected_xlates[$];

  int   err_count   = 0;
  bit   idle_on     = 1'b1;
  bit   cfg_pending = 1'b0;
  logic [cbm_pkg::MTYPE_W-1:0] cfg_value = '0;
  int   hold_request = 0;

  cartridge_bank_mapper DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_target          (out_target),
    .out_mapped_address  (out_mapped_address),
    .out_stores_data     (out_stores_data),
    .out_rom_bank_now    (out_rom_bank_now),
    .out_ram_bank_now    (out_ram_bank_now),
    .out_ram_enabled_now (out_ram_enabled_now)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Bank register update for writes below 0x8000
  function automatic void load_bank_regs(logic [cbm_pkg::ADDR_W-1:0] addr,
                                         logic [cbm_pkg::DATA_W-1:0] data);
    logic mbc1;
    logic mbc2;
    mbc1 = (mapper_q == cbm_pkg::MAPPER_MBC1);
    mbc2 = (mapper_q == cbm_pkg::MAPPER_MBC2);
    case (addr[14:13])
      cbm_pkg::WIN_RAM_EN: begin
        if (mbc1 || mbc2) begin
          if (data[3:0] == cbm_pkg::RAM_EN_KEY) ram_en_q = 1'b1;
          else if (data[3:0] == cbm_pkg::RAM_DIS_KEY) ram_en_q = 1'b0;
        end
      end
      cbm_pkg::WIN_ROM_LO: begin
        if (mbc2) rom_bank_q = {3'b000, data[3:0]};
        else if (mbc1) rom_bank_q = {rom_bank_q[6:5], data[4:0]};
      end
      cbm_pkg::WIN_ROM_HI: begin
        if (mbc1) begin
          if (rom_mode_q) rom_bank_q = {data[1:0], rom_bank_q[4:0]};
          else ram_bank_q = data[1:0];
        end
      end
      cbm_pkg::WIN_MODE: begin
        if (mbc1) begin
          rom_mode_q = ~data[0];
          if (rom_mode_q) ram_bank_q = 2'd0;
        end
      end
      default: begin
      end
    endcase
    // bank zero is never selected
    if (rom_bank_q == 7'd0) rom_bank_q = 7'd1;
  endfunction

  // Translate one access and advance the bank state
  function automatic xlate_t translate_access(cbm_pkg::req_t acc);
    xlate_t r;
    logic [cbm_pkg::ADDR_W-1:0] a;
    a = acc.address;
    r.target = cbm_pkg::TGT_BASE;
    r.mapped = {5'b0, a};
    r.stores = 1'b0;
    if (acc.is_write == ACC_READ) begin
      if (a >= 16'h4000 && a < 16'h8000) begin
        r.target = cbm_pkg::TGT_ROM;
        r.mapped = {rom_bank_q, a[13:0]};
      end else if (a >= 16'hA000 && a < 16'hC000) begin
        r.target = cbm_pkg::TGT_EXT_RAM;
        r.mapped = {6'b0, ram_bank_q, a[12:0]};
      end
    end else begin
      if (a < 16'h8000) begin
        r.target = cbm_pkg::TGT_BANK_REG;
        load_bank_regs(a, acc.write_data);
      end else if (a >= 16'hA000 && a < 16'hC000) begin
        r.mapped = {6'b0, ram_bank_q, a[12:0]};
        r.target = ram_en_q ? cbm_pkg::TGT_EXT_RAM : cbm_pkg::TGT_RAM_DROP;
        r.stores = ram_en_q;
      end else begin
        // restricted area swallows writes
        r.stores = !(a >= cbm_pkg::RESTRICT_LO && a < cbm_pkg::RESTRICT_HI);
      end
    end
    r.rom_bank = rom_bank_q;
    r.ram_bank = ram_bank_q;
    r.ram_en   = ram_en_q;
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Config channel: one register write per request
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mapper_q = cfg_data;
      cfg_valid <= 1'b0;
    end else if (!cfg_valid && cfg_pending) begin
      cfg_valid <= 1'b1;
      cfg_data <= cfg_value;
      cfg_pending = 1'b0;
    end
  end

  // Input driver: predict on each accepted beat, then offer the next access
  always @(posedge clk) begin : drive_in
    int            gap_left;
    logic          nxt_valid;
    cbm_pkg::req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_xlates.push_back(translate_access({in_req_type, in_address, in_write_data}));
      if (!in_valid || in_ready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 14);
          end else begin
            nxt = access_q.pop_front();
            nxt_valid = 1'b1;
            in_req_type <= nxt.is_write;
            in_address <= nxt.address;
            in_write_data <= nxt.write_data;
          end
        end
        in_valid <= nxt_valid;
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : watch_out
    int     hold_left;
    int     stall_left;
    logic   nxt_ready;
    xlate_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_xlates.size() == 0) begin
          flag_error($sformatf("result beat with nothing expected, addr 0x%0h",
                               out_mapped_address));
        end else begin
          want = expected_xlates.pop_front();
          if (out_target !== want.target)
            flag_error($sformatf("target got %0d want %0d", out_target, want.target));
          if (out_mapped_address !== want.mapped)
            flag_error($sformatf("mapped_address got 0x%0h want 0x%0h",
                                 out_mapped_address, want.mapped));
          if (out_stores_data !== want.stores)
            flag_error($sformatf("stores_data got %0b want %0b", out_stores_data, want.stores));
          if (out_rom_bank_now !== want.rom_bank)
            flag_error($sformatf("rom_bank_now got %0d want %0d",
                                 out_rom_bank_now, want.rom_bank));
          if (out_ram_bank_now !== want.ram_bank)
            flag_error($sformatf("ram_bank_now got %0d want %0d",
                                 out_ram_bank_now, want.ram_bank));
          if (out_ram_enabled_now !== want.ram_en)
            flag_error($sformatf("ram_enabled_now got %0b want %0b",
                                 out_ram_enabled_now, want.ram_en));
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      nxt_ready = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0 && idle_on) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        nxt_ready = 1'b0;
      end
      out_ready <= nxt_ready;
    end
  end

  task automatic queue_access(logic w, logic [cbm_pkg::ADDR_W-1:0] a,
                              logic [cbm_pkg::DATA_W-1:0] d);
    cbm_pkg::req_t acc;
    acc.is_write = w;
    acc.address = a;
    acc.write_data = d;
    access_q.push_back(acc);
  endtask

  // Random accesses, weighted toward bank writes and the banked windows
  task automatic queue_random(int n);
    int                         sel;
    logic                       w;
    logic [cbm_pkg::ADDR_W-1:0] a;
    logic [cbm_pkg::DATA_W-1:0] d;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      w = 1'($urandom_range(0, 1));
      a = 16'($urandom);
      d = 8'($urandom);
      if (sel < 4) begin
        w = ACC_WRITE;
        a = {1'b0, a[14:0]};
        if (a[14:13] == cbm_pkg::WIN_RAM_EN && $urandom_range(0, 1) == 1)
          d[3:0] = ($urandom_range(0, 1) == 1) ? cbm_pkg::RAM_EN_KEY : cbm_pkg::RAM_DIS_KEY;
      end else if (sel < 6) begin
        w = ACC_READ;
        a = {2'b01, a[13:0]};
      end else if (sel < 8) begin
        a = {3'b101, a[12:0]};
      end else if (sel == 8) begin
        a = 16'hFE80 + 16'($urandom_range(0, 127));
      end
      queue_access(w, a, d);
    end
  endtask

  // Wait until every queued access has been answered, then let the pipe settle
  task automatic wait_quiet();
    do @(negedge clk);
    while (access_q.size() != 0 || in_valid || expected_xlates.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mapper(logic [cbm_pkg::MTYPE_W-1:0] v);
    @(negedge clk);
    cfg_value = v;
    cfg_pending = 1'b1;
    do @(negedge clk);
    while (cfg_pending || cfg_valid);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // No mapper: bank writes change nothing, RAM stays disabled
    queue_access(ACC_WRITE, 16'h0000, 8'h0A);
    queue_access(ACC_WRITE, 16'h2000, 8'h05);
    queue_access(ACC_READ,  16'h4000, 8'hFF);
    queue_access(ACC_WRITE, 16'hA000, 8'h12);
    wait_quiet();

    // MBC1 directed
    set_mapper(cbm_pkg::MAPPER_MBC1);
    queue_access(ACC_WRITE, 16'h0000, 8'h0A);   // RAM on
    queue_access(ACC_WRITE, 16'hA000, 8'h55);   // stored
    queue_access(ACC_WRITE, 16'h2000, 8'h00);   // bank zero bumps to one
    queue_access(ACC_WRITE, 16'h2000, 8'hFF);
    queue_access(ACC_WRITE, 16'h4000, 8'h03);   // high bits, bank 127
    queue_access(ACC_READ,  16'h7FFF, 8'h00);   // top of ROM space
    queue_access(ACC_WRITE, 16'h6000, 8'h01);   // RAM banking mode
    queue_access(ACC_WRITE, 16'h4000, 8'hFE);
    queue_access(ACC_READ,  16'hBFFF, 8'h00);
    queue_access(ACC_WRITE, 16'h0000, 8'h05);   // neither key
    queue_access(ACC_WRITE, 16'h0000, 8'hF0);   // RAM off
    queue_access(ACC_WRITE, 16'hBFFF, 8'hAA);   // dropped
    queue_access(ACC_WRITE, 16'h6000, 8'h00);   // ROM mode clears RAM bank
    queue_access(ACC_WRITE, 16'hFEA0, 8'h01);
    queue_access(ACC_WRITE, 16'hFEFE, 8'h02);
    queue_access(ACC_WRITE, 16'hFEFF, 8'h03);
    queue_access(ACC_READ,  16'h0000, 8'h00);
    queue_access(ACC_READ,  16'hFFFF, 8'h00);
    wait_quiet();

    // MBC2 directed: four-bit bank, upper windows ignored
    set_mapper(cbm_pkg::MAPPER_MBC2);
    queue_access(ACC_WRITE, 16'h2000, 8'hF0);
    queue_access(ACC_WRITE, 16'h3FFF, 8'h0F);
    queue_access(ACC_WRITE, 16'h5FFF, 8'h03);
    queue_access(ACC_WRITE, 16'h7FFF, 8'h01);
    wait_quiet();

    // Unused mapper code behaves like none
    set_mapper(MAPPER_UNUSED);
    queue_access(ACC_WRITE, 16'h1FFF, 8'h0A);
    queue_access(ACC_WRITE, 16'h2000, 8'h1F);
    wait_quiet();

    // Random MBC1, with a long receiver hold so the input backs up
    set_mapper(cbm_pkg::MAPPER_MBC1);
    queue_random(200);
    @(negedge clk);
    hold_request = LONG_HOLD;
    wait_quiet();

    // Random MBC2, with a sender pause until everything has drained
    set_mapper(cbm_pkg::MAPPER_MBC2);
    queue_random(50);
    wait_quiet();
    queue_random(50);
    wait_quiet();

    set_mapper(cbm_pkg::MAPPER_NONE);
    queue_random(50);
    wait_quiet();

    set_mapper(MAPPER_UNUSED);
    queue_random(20);
    wait_quiet();

    // Last stretch at full rate
    set_mapper(cbm_pkg::MAPPER_MBC1);
    idle_on = 1'b0;
    queue_random(130);
    wait_quiet();

    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
